/* hw/rtl/wmbts_pkg.sv */
// shared types, codes and bcd step functions of the watch mode controller
`default_nettype none

package wmbts_pkg;

    // action codes of an input transaction
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_BTN_C = 3'd1;
    localparam logic [2:0] ACT_BTN_L = 3'd2;
    localparam logic [2:0] ACT_BTN_A = 3'd3;
    localparam logic [2:0] ACT_ALARM = 3'd4;

    // watch modes
    localparam logic [1:0] MODE_TIME  = 2'd0;
    localparam logic [1:0] MODE_ALARM = 2'd1;
    localparam logic [1:0] MODE_STOPW = 2'd2;
    localparam logic [1:0] MODE_SET   = 2'd3;

    // field selects of the setting counter
    localparam logic [2:0] SEL_SECONDS   = 3'd0;
    localparam logic [2:0] SEL_HOURS     = 3'd1;
    localparam logic [2:0] SEL_MINUTES   = 3'd2;
    localparam logic [2:0] SEL_DAY       = 3'd3;
    localparam logic [2:0] SEL_MONTH     = 3'd4;
    localparam logic [2:0] SEL_YEAR_TENS = 3'd5;
    localparam logic [2:0] SEL_YEAR_ONES = 3'd6;
    localparam logic [2:0] SEL_WEEKDAY   = 3'd7;
    localparam logic [2:0] SEL_ALM_DONE  = 3'd3;
    localparam logic [2:0] SEL_SET_DONE  = 3'd7;

    localparam int unsigned TIMEOUT_W = 20;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd20000;
    localparam logic [2:0] WEEKDAY_LAST = 3'd6;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] rtc_hours;
        logic [7:0] rtc_minutes;
        logic [7:0] rtc_seconds;
        logic [7:0] rtc_day;
        logic [7:0] rtc_month;
        logic [7:0] rtc_year;
        logic [2:0] rtc_weekday;
        logic [7:0] rtc_alarm_hours;
        logic [7:0] rtc_alarm_minutes;
    } item_t;

    typedef struct packed {
        logic [1:0] mode_now;
        logic [2:0] setting_now;
        logic       buzzer_on;
        logic       write_time;
        logic       write_alarm;
        logic [7:0] shown_hours;
        logic [7:0] shown_minutes;
        logic [7:0] edit_seconds;
        logic [7:0] edit_day;
        logic [7:0] edit_month;
        logic [7:0] edit_year;
        logic [2:0] edit_weekday;
    } result_t;

    // buzzer state before and after the current transaction
    typedef struct packed {
        logic ringing;
        logic ringing_next;
    } buzz_stat_t;

    // editor state after the current transaction, plus commit pulses
    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] setting;
        logic [7:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [2:0] weekday;
        logic [7:0] alarm_hours;
        logic [7:0] alarm_minutes;
        logic       write_time;
        logic       write_alarm;
    } edit_view_t;

    function automatic logic [7:0] bump_hours(input logic [7:0] v);
        logic [7:0] r;
        r = v + 8'h01;
        if (r == 8'h24) r = 8'h00;
        if (r[3:0] == 4'hA) r = r + 8'h06;
        return r;
    endfunction

    function automatic logic [7:0] bump_minutes(input logic [7:0] v);
        logic [7:0] r;
        r = v + 8'h01;
        if (r == 8'h5A) r = 8'h00;
        if (r[3:0] == 4'hA) r = r + 8'h06;
        return r;
    endfunction

    function automatic logic [7:0] bump_day(input logic [7:0] v);
        logic [7:0] r;
        r = v + 8'h01;
        if (r == 8'h32) r = 8'h01;
        if (r[3:0] == 4'hA) r = r + 8'h06;
        return r;
    endfunction

    function automatic logic [7:0] bump_month(input logic [7:0] v);
        logic [7:0] r;
        r = v + 8'h01;
        if (r == 8'h13) r = 8'h01;
        if (r == 8'h0A) r = 8'h10;
        return r;
    endfunction

    function automatic logic [7:0] bump_year_tens(input logic [7:0] v);
        logic [7:0] r;
        r = v + 8'h10;
        if (r > 8'h99) r = r - 8'hA0;
        return r;
    endfunction

    function automatic logic [7:0] bump_year_ones(input logic [7:0] v);
        logic [7:0] r;
        r = v + 8'h01;
        if (r[3:0] == 4'hA) r = r - 8'h0A;
        return r;
    endfunction

    function automatic logic [2:0] bump_weekday(input logic [2:0] v);
        logic [2:0] r;
        r = (v >= WEEKDAY_LAST) ? 3'd0 : v + 3'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/wmbts_stream_if.sv */
// valid/ready channel carrying one payload per transaction
`default_nettype none

interface wmbts_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/wmbts_buzzer.sv */
// alarm buzzer state and its timeout counter
`default_nettype none

module wmbts_buzzer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step_en,
    input  wire logic [2:0]                     action,
    input  wire logic [wmbts_pkg::TIMEOUT_W-1:0] timeout,
    output wmbts_pkg::buzz_stat_t               stat
);
    import wmbts_pkg::*;

    logic                 ringing_reg;
    logic                 ringing_next;
    logic [TIMEOUT_W-1:0] ticks_reg;
    logic [TIMEOUT_W-1:0] ticks_next;
    logic [TIMEOUT_W-1:0] ticks_inc;

    assign ticks_inc = ticks_reg + TIMEOUT_W'(1);

    // ring start, silence and timeout
    always_comb
    begin
        ringing_next = ringing_reg;
        ticks_next   = ticks_reg;
        unique case (action)
            ACT_TICK:
            begin
                if (ringing_reg)
                begin
                    if (ticks_inc >= timeout)
                    begin
                        ringing_next = 1'b0;
                        ticks_next   = '0;
                    end
                    else
                    begin
                        ticks_next = ticks_inc;
                    end
                end
            end
            ACT_BTN_L:
            begin
                if (ringing_reg)
                begin
                    ringing_next = 1'b0;
                    ticks_next   = '0;
                end
            end
            ACT_ALARM:
            begin
                ringing_next = 1'b1;
                ticks_next   = '0;
            end
            default:
            begin
                ringing_next = ringing_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ringing_reg <= 1'b0;
            ticks_reg   <= '0;
        end
        else if (step_en)
        begin
            ringing_reg <= ringing_next;
            ticks_reg   <= ticks_next;
        end
    end

    assign stat.ringing      = ringing_reg;
    assign stat.ringing_next = ringing_next;

endmodule

`default_nettype wire

/* hw/rtl/wmbts_editor.sv */
// mode and setting counters, edited time/date and alarm copies
`default_nettype none

module wmbts_editor (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step_en,
    input  wire wmbts_pkg::item_t item,
    input  wire logic             ringing,
    output wmbts_pkg::edit_view_t view
);
    import wmbts_pkg::*;

    edit_view_t st_reg;
    edit_view_t st_next;
    logic [1:0] mode_inc;
    logic [2:0] setting_inc;

    assign mode_inc    = st_reg.mode + 2'd1;
    assign setting_inc = st_reg.setting + 3'd1;

    // next editor state for one transaction
    always_comb
    begin
        st_next             = st_reg;
        st_next.write_time  = 1'b0;
        st_next.write_alarm = 1'b0;
        unique case (item.action)
            ACT_BTN_C:
            begin
                st_next.setting = '0;
                if (st_reg.mode == MODE_SET)
                begin
                    st_next.mode       = MODE_TIME;
                    st_next.write_time = (st_reg.setting == SEL_SET_DONE);
                end
                else
                begin
                    st_next.mode = mode_inc;
                    if (mode_inc == MODE_ALARM)
                    begin
                        st_next.alarm_hours   = item.rtc_alarm_hours;
                        st_next.alarm_minutes = item.rtc_alarm_minutes;
                    end
                    else if (mode_inc == MODE_SET)
                    begin
                        st_next.hours   = item.rtc_hours;
                        st_next.minutes = item.rtc_minutes;
                        st_next.seconds = item.rtc_seconds;
                        st_next.day     = item.rtc_day;
                        st_next.month   = item.rtc_month;
                        st_next.year    = item.rtc_year;
                        st_next.weekday = (item.rtc_weekday > WEEKDAY_LAST) ?
                                          3'd0 : item.rtc_weekday;
                    end
                end
            end
            ACT_BTN_L:
            begin
                if (!ringing)
                begin
                    if (st_reg.mode == MODE_ALARM && setting_inc == SEL_ALM_DONE)
                    begin
                        st_next.setting     = '0;
                        st_next.write_alarm = 1'b1;
                    end
                    else
                    begin
                        st_next.setting = setting_inc;
                    end
                end
            end
            ACT_BTN_A:
            begin
                if (st_reg.mode == MODE_ALARM)
                begin
                    if (st_reg.setting == SEL_HOURS)
                        st_next.alarm_hours = bump_hours(st_reg.alarm_hours);
                    else if (st_reg.setting == SEL_MINUTES)
                        st_next.alarm_minutes = bump_minutes(st_reg.alarm_minutes);
                end
                else if (st_reg.mode == MODE_SET)
                begin
                    unique case (st_reg.setting)
                        SEL_SECONDS:   st_next.seconds = 8'h00;
                        SEL_HOURS:     st_next.hours   = bump_hours(st_reg.hours);
                        SEL_MINUTES:   st_next.minutes = bump_minutes(st_reg.minutes);
                        SEL_DAY:       st_next.day     = bump_day(st_reg.day);
                        SEL_MONTH:     st_next.month   = bump_month(st_reg.month);
                        SEL_YEAR_TENS: st_next.year    = bump_year_tens(st_reg.year);
                        SEL_YEAR_ONES: st_next.year    = bump_year_ones(st_reg.year);
                        default:       st_next.weekday = bump_weekday(st_reg.weekday);
                    endcase
                end
            end
            default:
            begin
                st_next.setting = st_reg.setting;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (step_en)
            st_reg <= st_next;
    end

    assign view = st_next;

endmodule

`default_nettype wire

/* hw/rtl/watch_mode_and_bcd_time_setter.sv */
// top level of the three-button watch mode controller
`default_nettype none

// Three-button watch controller: button C rotates through time, alarm, stopwatch and
// set modes, L steps the field under edit (or silences the buzzer), A bumps
// the selected BCD field, ticks time out a ringing buzzer. One transaction
// is accepted every clock cycle while the result register is free; each
// gives exactly one result transaction, which passes through the input
// register, then the result register. The input register holds while the
// result register is full and not taken, so throughput follows the result
// channel. The user writes buzzer_timeout_ticks via cfg_wr_en/cfg_wr_data
// only while no transaction is in flight; the block does not enforce this.
module watch_mode_and_bcd_time_setter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [wmbts_pkg::TIMEOUT_W-1:0] cfg_wr_data,
    wmbts_stream_if.sink                         item,
    wmbts_stream_if.source                       result
);
    import wmbts_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_val_reg;
    logic                 s1_valid_reg;
    item_t                s1_item_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    result_t              out_next;
    logic                 out_free;
    logic                 step_en;
    buzz_stat_t           buzz;
    edit_view_t           view;

    // timeout configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_val_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_val_reg <= cfg_wr_data;
        end
    end

    // handshake between input register and result register
    assign out_free    = !out_valid_reg || result.ready;
    assign step_en     = s1_valid_reg && out_free;
    assign item.ready  = !s1_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            s1_item_reg <= item.payload;
    end

    wmbts_buzzer u_buzzer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .action  (s1_item_reg.action),
        .timeout (timeout_val_reg),
        .stat    (buzz)
    );

    wmbts_editor u_editor (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (s1_item_reg),
        .ringing (buzz.ringing),
        .view    (view)
    );

    // result assembly, alarm copy shown in alarm mode
    always_comb
    begin
        out_next.mode_now      = view.mode;
        out_next.setting_now   = view.setting;
        out_next.buzzer_on     = buzz.ringing_next;
        out_next.write_time    = view.write_time;
        out_next.write_alarm   = view.write_alarm;
        out_next.shown_hours   = (view.mode == MODE_ALARM) ? view.alarm_hours : view.hours;
        out_next.shown_minutes = (view.mode == MODE_ALARM) ? view.alarm_minutes :
                                                             view.minutes;
        out_next.edit_seconds  = view.seconds;
        out_next.edit_day      = view.day;
        out_next.edit_month    = view.month;
        out_next.edit_year     = view.year;
        out_next.edit_weekday  = view.weekday;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_reg <= out_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

`default_nettype wire

/* tb/watch_mode_and_bcd_time_setter_tb.sv */
// testbench for the three-button watch mode controller: directed and random button sequences
`default_nettype none

module watch_mode_and_bcd_time_setter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wmbts_pkg::*;

    // action codes that the block ignores
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned MAX_PRINTED = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [TIMEOUT_W-1:0] cfg_wr_data = '0;

    wmbts_stream_if #(.payload_t(item_t))   item_ch ();
    wmbts_stream_if #(.payload_t(result_t)) result_ch ();

    watch_mode_and_bcd_time_setter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watch state as the block should hold it
    logic [1:0]           w_mode = MODE_TIME;
    logic [2:0]           w_setting = SEL_SECONDS;
    logic [7:0]           w_hours = '0;
    logic [7:0]           w_minutes = '0;
    logic [7:0]           w_seconds = '0;
    logic [7:0]           w_day = '0;
    logic [7:0]           w_month = '0;
    logic [7:0]           w_year = '0;
    logic [2:0]           w_weekday = '0;
    logic [7:0]           w_alm_hours = '0;
    logic [7:0]           w_alm_minutes = '0;
    logic                 w_ringing = 1'b0;
    logic [TIMEOUT_W-1:0] w_ring_cnt = '0;
    logic [TIMEOUT_W-1:0] w_timeout = TIMEOUT_RESET;

    result_t     view_q[$];
    result_t     pred_view;
    result_t     got_view;
    result_t     want_view;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned useful_items = 0;
    logic [1:0]  stim_mode = MODE_TIME;
    bit          src_idle = 1'b1;
    bit          snk_idle = 1'b1;
    int unsigned stall_left = 0;

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %02h want %02h", name, got, want));
    endtask

    // one bcd increment: wrap at limit to restart, then skip the hex digits
    function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic [7:0] limit_val,
                                            input logic [7:0] restart);
        logic [7:0] r;
        r = v + 8'h01;
        if (r == limit_val)
            r = restart;
        if (r[3:0] == 4'hA)
            r = r + 8'h06;
        return r;
    endfunction

    // button A on the field under edit
    task automatic apply_button_a();
        if (w_mode == MODE_ALARM)
        begin
            if (w_setting == SEL_HOURS)
                w_alm_hours = bcd_step(w_alm_hours, 8'h24, 8'h00);
            else if (w_setting == SEL_MINUTES)
                w_alm_minutes = bcd_step(w_alm_minutes, 8'h5A, 8'h00);
        end
        else if (w_mode == MODE_SET)
        begin
            case (w_setting)
                SEL_SECONDS: w_seconds = 8'h00;
                SEL_HOURS:   w_hours = bcd_step(w_hours, 8'h24, 8'h00);
                SEL_MINUTES: w_minutes = bcd_step(w_minutes, 8'h5A, 8'h00);
                SEL_DAY:     w_day = bcd_step(w_day, 8'h32, 8'h01);
                SEL_MONTH:
                begin
                    w_month = w_month + 8'h01;
                    if (w_month == 8'h13)
                        w_month = 8'h01;
                    if (w_month == 8'h0A)
                        w_month = 8'h10;
                end
                SEL_YEAR_TENS:
                begin
                    w_year = w_year + 8'h10;
                    if (w_year > 8'h99)
                        w_year = w_year - 8'hA0;
                end
                SEL_YEAR_ONES:
                begin
                    w_year = w_year + 8'h01;
                    if (w_year[3:0] == 4'hA)
                        w_year = w_year - 8'h0A;
                end
                default: w_weekday = (w_weekday >= 3'd6) ? 3'd0 : w_weekday + 3'd1;
            endcase
        end
    endtask

    // advance the watch state by one transaction and form the outputs
    task automatic advance_watch(input item_t it, output result_t v);
        logic wt;
        logic wa;
        wt = 1'b0;
        wa = 1'b0;
        case (it.action)
            ACT_TICK:
            begin
                if (w_ringing)
                begin
                    w_ring_cnt = w_ring_cnt + TIMEOUT_W'(1);
                    if (w_ring_cnt >= w_timeout)
                    begin
                        w_ringing = 1'b0;
                        w_ring_cnt = '0;
                    end
                end
            end
            ACT_BTN_C:
            begin
                if (w_mode == MODE_SET)
                begin
                    wt = (w_setting == SEL_SET_DONE);
                    w_mode = MODE_TIME;
                end
                else
                begin
                    w_mode = w_mode + 2'd1;
                    if (w_mode == MODE_ALARM)
                    begin
                        w_alm_hours = it.rtc_alarm_hours;
                        w_alm_minutes = it.rtc_alarm_minutes;
                    end
                    else if (w_mode == MODE_SET)
                    begin
                        w_hours = it.rtc_hours;
                        w_minutes = it.rtc_minutes;
                        w_seconds = it.rtc_seconds;
                        w_day = it.rtc_day;
                        w_month = it.rtc_month;
                        w_year = it.rtc_year;
                        w_weekday = (it.rtc_weekday > WEEKDAY_LAST) ? 3'd0 : it.rtc_weekday;
                    end
                end
                w_setting = SEL_SECONDS;
            end
            ACT_BTN_L:
            begin
                if (w_ringing)
                begin
                    w_ringing = 1'b0;
                    w_ring_cnt = '0;
                end
                else
                begin
                    w_setting = w_setting + 3'd1;
                    if (w_mode == MODE_ALARM && w_setting == SEL_ALM_DONE)
                    begin
                        wa = 1'b1;
                        w_setting = SEL_SECONDS;
                    end
                end
            end
            ACT_BTN_A: apply_button_a();
            ACT_ALARM:
            begin
                w_ringing = 1'b1;
                w_ring_cnt = '0;
            end
            default: ;
        endcase
        v.mode_now = w_mode;
        v.setting_now = w_setting;
        v.buzzer_on = w_ringing;
        v.write_time = wt;
        v.write_alarm = wa;
        v.shown_hours = (w_mode == MODE_ALARM) ? w_alm_hours : w_hours;
        v.shown_minutes = (w_mode == MODE_ALARM) ? w_alm_minutes : w_minutes;
        v.edit_seconds = w_seconds;
        v.edit_day = w_day;
        v.edit_month = w_month;
        v.edit_year = w_year;
        v.edit_weekday = w_weekday;
    endtask

    // track config writes, predict accepted items, check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                w_timeout = cfg_wr_data;
            if (item_ch.valid && item_ch.ready)
            begin
                advance_watch(item_ch.payload, pred_view);
                view_q.push_back(pred_view);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got_view = result_ch.payload;
                if (view_q.size() == 0)
                    flag_error("result transaction with nothing expected");
                else
                begin
                    want_view = view_q.pop_front();
                    check_field("mode_now", 8'(got_view.mode_now), 8'(want_view.mode_now));
                    check_field("setting_now", 8'(got_view.setting_now),
                                8'(want_view.setting_now));
                    check_field("buzzer_on", 8'(got_view.buzzer_on), 8'(want_view.buzzer_on));
                    check_field("write_time", 8'(got_view.write_time),
                                8'(want_view.write_time));
                    check_field("write_alarm", 8'(got_view.write_alarm),
                                8'(want_view.write_alarm));
                    check_field("shown_hours", got_view.shown_hours, want_view.shown_hours);
                    check_field("shown_minutes", got_view.shown_minutes,
                                want_view.shown_minutes);
                    check_field("edit_seconds", got_view.edit_seconds, want_view.edit_seconds);
                    check_field("edit_day", got_view.edit_day, want_view.edit_day);
                    check_field("edit_month", got_view.edit_month, want_view.edit_month);
                    check_field("edit_year", got_view.edit_year, want_view.edit_year);
                    check_field("edit_weekday", 8'(got_view.edit_weekday),
                                8'(want_view.edit_weekday));
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else if (snk_idle && rst_n)
        begin
            stall_left = pick_gap();
            if (stall_left != 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
        else
            result_ch.ready <= rst_n;
    end

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 1) != 0)
            return 8'($urandom_range(0, 255));
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic item_t rand_item(input logic [2:0] act);
        item_t it;
        it.action = act;
        it.rtc_hours = rand_byte();
        it.rtc_minutes = rand_byte();
        it.rtc_seconds = rand_byte();
        it.rtc_day = rand_byte();
        it.rtc_month = rand_byte();
        it.rtc_year = rand_byte();
        it.rtc_weekday = 3'($urandom_range(0, 7));
        it.rtc_alarm_hours = rand_byte();
        it.rtc_alarm_minutes = rand_byte();
        return it;
    endfunction

    // present one transaction, wait for it to be taken, then maybe pause
    task automatic send_item(input item_t it);
        int unsigned gap;
        item_ch.valid <= 1'b1;
        item_ch.payload <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (it.action == ACT_BTN_C)
            stim_mode = (stim_mode == MODE_SET) ? MODE_TIME : stim_mode + 2'd1;
        useful_items++;
        gap = src_idle ? pick_gap() : 0;
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_act(input logic [2:0] act);
        send_item(rand_item(act));
    endtask

    // stop sending and wait for every expected result
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (view_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] ticks);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mode walk through alarm editing and every set field with bcd edge values
    task automatic test_directed_walk();
        item_t it;
        send_act(ACT_BTN_A);
        it = rand_item(ACT_BTN_C);
        it.rtc_alarm_hours = 8'h23;
        it.rtc_alarm_minutes = 8'h59;
        send_item(it);
        send_act(ACT_BTN_A);
        send_act(ACT_BTN_L);
        send_act(ACT_BTN_A);
        send_act(ACT_BTN_L);
        send_act(ACT_BTN_A);
        send_act(ACT_BTN_L);
        send_act(ACT_BTN_C);
        send_act(ACT_BTN_A);
        it = rand_item(ACT_BTN_C);
        it.rtc_hours = 8'h19;
        it.rtc_minutes = 8'hFF;
        it.rtc_seconds = 8'h45;
        it.rtc_day = 8'h31;
        it.rtc_month = 8'h09;
        it.rtc_year = 8'h99;
        it.rtc_weekday = 3'd7;
        send_item(it);
        send_act(ACT_BTN_A);
        repeat (7)
        begin
            send_act(ACT_BTN_L);
            send_act(ACT_BTN_A);
        end
        send_act(ACT_BTN_C);
    endtask

    // buzzer against buttons, raw all-ones snapshot, weekday wrap, ignored codes
    task automatic test_misc_buttons();
        item_t it;
        send_act(ACT_ALARM);
        send_act(ACT_BTN_C);
        send_act(ACT_BTN_L);
        send_act(ACT_BTN_L);
        send_act(ACT_BTN_C);
        it = '1;
        it.action = ACT_BTN_C;
        it.rtc_weekday = WEEKDAY_LAST;
        send_item(it);
        send_act(ACT_BTN_L);
        send_act(ACT_BTN_A);
        repeat (6) send_act(ACT_BTN_L);
        send_act(ACT_BTN_A);
        send_act(ACT_BTN_C);
        for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
            send_act(3'(a));
        send_act(ACT_TICK);
    endtask

    // buzzer keeps ringing through a tick run well short of the reset timeout
    task automatic test_default_timeout();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        send_act(ACT_ALARM);
        repeat (40) send_act(ACT_TICK);
        src_idle = 1'b1;
        snk_idle = 1'b1;
        send_act(ACT_BTN_L);
    endtask

    // short timeouts, restart by a new alarm, silence at the longest timeout
    task automatic test_buzzer_timeout();
        write_timeout(20'd1);
        send_act(ACT_ALARM);
        send_act(ACT_TICK);
        send_act(ACT_TICK);
        write_timeout(20'd3);
        send_act(ACT_ALARM);
        send_act(ACT_TICK);
        send_act(ACT_TICK);
        send_act(ACT_ALARM);
        repeat (4) send_act(ACT_TICK);
        write_timeout('1);
        send_act(ACT_ALARM);
        repeat (5) send_act(ACT_TICK);
        send_act(ACT_BTN_L);
        send_act(ACT_TICK);
    endtask

    function automatic int unsigned press_count();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(4, 25);
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [2:0] pick_action();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return ACT_TICK;
        if (r < 45)
            return ACT_BTN_C;
        if (r < 62)
            return ACT_BTN_L;
        if (r < 82)
            return ACT_BTN_A;
        if (r < 92)
            return ACT_ALARM;
        return 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    endfunction

    // enter set mode, edit fields in order, leave (mostly with a commit)
    task automatic run_set_session();
        int unsigned last_field;
        int unsigned f;
        // silences a leftover ring; C clears the setting unless already in set mode
        send_act(ACT_BTN_L);
        while (stim_mode != MODE_SET)
            send_act(ACT_BTN_C);
        last_field = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 7;
        for (f = 0; f <= last_field; f++)
        begin
            if (f != 0)
                send_act(ACT_BTN_L);
            repeat (press_count())
            begin
                send_act(ACT_BTN_A);
                if ($urandom_range(0, 15) == 0)
                    send_act(ACT_TICK);
            end
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_act(ACT_BTN_L);
        send_act(ACT_BTN_C);
    endtask

    // enter alarm mode, edit hours and minutes, try to commit
    task automatic run_alarm_session();
        send_act(ACT_BTN_L);
        while (stim_mode != MODE_ALARM)
            send_act(ACT_BTN_C);
        send_act(ACT_BTN_L);
        repeat (press_count()) send_act(ACT_BTN_A);
        send_act(ACT_BTN_L);
        repeat (press_count()) send_act(ACT_BTN_A);
        send_act(ACT_BTN_L);
    endtask

    // random actions, with tick bursts to reach the buzzer timeout
    task automatic run_noise();
        logic [2:0] act;
        repeat ($urandom_range(5, 20))
        begin
            act = pick_action();
            if (act == ACT_TICK && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 12)) send_act(ACT_TICK);
            else
                send_act(act);
        end
    endtask

    task automatic run_random_phase(input int unsigned target);
        int unsigned start;
        int unsigned kind;
        start = useful_items;
        while (useful_items - start < target)
        begin
            // flip idling now and then so that idle-free stretches occur
            if ($urandom_range(0, 7) == 0)
                src_idle = !src_idle;
            if ($urandom_range(0, 7) == 0)
                snk_idle = !snk_idle;
            kind = $urandom_range(0, 19);
            if (kind < 8)
                run_set_session();
            else if (kind < 13)
                run_alarm_session();
            else
                run_noise();
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    // stimulus
    initial
    begin
        int unsigned i;
        item_ch.valid = 1'b0;
        item_ch.payload = '0;
        result_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_walk();
        test_misc_buttons();
        test_default_timeout();
        test_buzzer_timeout();

        write_timeout(20'd1);
        run_random_phase(350);
        write_timeout(TIMEOUT_W'($urandom_range(2, 8)));
        run_random_phase(350);
        write_timeout('1);
        run_random_phase(350);
        write_timeout(TIMEOUT_W'($urandom_range(1, 12)));
        run_random_phase(350);

        // drain, then watch for stray results
        item_ch.valid <= 1'b0;
        for (i = 0; i < 5000 && view_q.size() != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (view_q.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", view_q.size()));

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
